@@ src/circle_trajectory_setpoint_defines.svh @@
// assertion helpers for the circle setpoint block
`ifndef CIRCLE_TRAJECTORY_SETPOINT_DEFINES_SVH
`define CIRCLE_TRAJECTORY_SETPOINT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CTSP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctsp assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define CTSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctsp assertion failed");

`endif

@@ src/ctsp_pkg.sv @@
package ctsp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 16;

   localparam int IDX_W = $clog2(CORDIC_STAGES);
   localparam int CW    = FRAC_BITS + 3;
   localparam int PW    = 32 + CW;
   localparam int WSW   = PW - FRAC_BITS;
   localparam int QW    = 32 + WSW;
   localparam int WWW   = QW - 16;
   localparam int LO_W  = 24;
   localparam int HI_W  = WWW - LO_W;
   localparam int LOP_W = 31 + LO_W;
   localparam int HIP_W = 32 + HI_W;
   localparam int SUMW  = 32 + WWW;
   localparam int HW    = 34;
   localparam int MAG_W = 62;
   localparam int REM_W = 35;
   localparam int RED_STEPS = 28;
   localparam int H_RSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int H_LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   typedef logic signed [95:0] wide_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [4:0] red_idx_type;

   typedef enum logic [2:0] {
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_CENTER_Z,
      REG_RADIUS,
      REG_ANGULAR_RATE
   } reg_index_type;

   localparam logic [MAG_W-1:0] TWO_PI_Q32 = MAG_W'(64'd26986075409);
   localparam logic [MAG_W-1:0] PI_Q32     = MAG_W'(64'd13493037705);
   localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
   localparam logic signed [18:0] HEAD_MAX    = 19'sd205887;

   localparam logic signed [31:0] ATAN_HEAD [11] = '{
      32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
      32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
      32'sd4194283, 32'sd2097149, 32'sd1048576
   };

   typedef struct packed {
      logic                 neg;
      logic [MAG_W-1:0]     mag;
   } red_word_type;

   typedef struct packed {
      logic                 flip;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } rot_word_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
   } side_type;

   typedef struct packed {
      logic                 zero;
      logic signed [HW-1:0] x;
      logic signed [HW-1:0] y;
      logic signed [CW-1:0] z;
      side_type             side;
   } vec_word_type;

   // round half up, arithmetic right shift
   function automatic wide_type rnd_shr(input wide_type v, input logic [6:0] s);
      wide_type half;
      half = (wide_type'(1) <<< s) >>> 1;
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type v);
      if (v > wide_type'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < wide_type'(-33'sh080000000)) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [CW-1:0] frac30(input wide_type v);
      return CW'(rnd_shr(v, 7'(30 - FRAC_BITS)));
   endfunction

   function automatic logic signed [CW-1:0] atan_frac(input idx_type i);
      logic [5:0]         ii;
      logic signed [31:0] v;
      ii = 6'(i);
      if (ii < 6'd11) v = ATAN_HEAD[ii[3:0]];
      else if (ii < 6'd31) v = 32'sd1 <<< (6'd30 - ii);
      else v = 32'sd0;
      return frac30(wide_type'(v));
   endfunction

   localparam logic signed [CW-1:0] GAIN_F    = frac30(wide_type'(GAIN_Q30));
   localparam logic signed [CW-1:0] HALF_PI_F = frac30(wide_type'(HALF_PI_Q30));
   localparam logic signed [CW-1:0] PI_F      = frac30(wide_type'(PI_Q30));

endpackage

@@ src/ctsp_if.sv @@
interface ctsp_req_if;
   logic        valid;
   logic        ready;
   logic [30:0] elapsed_time;
   modport source (output valid, elapsed_time, input ready);
   modport sink (input valid, elapsed_time, output ready);
endinterface

interface ctsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic signed [18:0] heading;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, acc_x, acc_y, heading,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, acc_x, acc_y, heading,
                 output ready);
endinterface

interface ctsp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/circle_trajectory_setpoint.sv @@
// channel  role   handshake     word
// req      sink   valid/ready   elapsed_time
// rsp      source valid/ready   pos_x pos_y pos_z vel_x vel_y acc_x acc_y heading
// csr      sink   valid/ready   index data (ready always high)
// one word per cycle while rsp is not stalled, through the 28 phase reduction cells,
// the two cordic cell rows of CORDIC_STAGES cells each and eleven other stages
// reset clears every stage valid and loads the register defaults
// every stage holds its word while the next one is full, so bubbles close up and
// req stays ready until the whole chain is full behind a stalled rsp
`include "circle_trajectory_setpoint_defines.svh"
module circle_trajectory_setpoint (
   input logic        clock,
   input logic        reset,
   ctsp_req_if.sink   req_port,
   ctsp_rsp_if.source rsp_port,
   ctsp_csr_if.sink   csr_port
);

   localparam int NS = ctsp_pkg::CORDIC_STAGES;
   localparam int NR = ctsp_pkg::RED_STEPS;

   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff, angular_rate_ff;
   logic [30:0]        radius_ff;
   logic signed [31:0] rad_s;

   assign rad_s = $signed({1'b0, radius_ff});
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= 32'sd0;
         center_y_ff     <= 32'sd0;
         center_z_ff     <= 32'sd131072;
         radius_ff       <= 31'd196608;
         angular_rate_ff <= 32'sd32768;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            ctsp_pkg::REG_CENTER_X:     center_x_ff     <= csr_port.data;
            ctsp_pkg::REG_CENTER_Y:     center_y_ff     <= csr_port.data;
            ctsp_pkg::REG_CENTER_Z:     center_z_ff     <= csr_port.data;
            ctsp_pkg::REG_RADIUS:       radius_ff       <= csr_port.data[30:0];
            ctsp_pkg::REG_ANGULAR_RATE: angular_rate_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   // phase product
   logic                   red_valid [NR+1];
   logic                   red_ready [NR+1];
   ctsp_pkg::red_word_type red_word  [NR+1];
   logic                   m_valid_ff;
   ctsp_pkg::red_word_type m_word_ff, m_word_in;
   logic signed [62:0]     m_prod;

   assign req_port.ready = !m_valid_ff || red_ready[0];

   always_comb begin
      m_prod = angular_rate_ff * $signed({1'b0, req_port.elapsed_time});
      m_word_in.neg = m_prod[62];
      m_word_in.mag = m_prod[62] ? ctsp_pkg::MAG_W'(-m_prod) : ctsp_pkg::MAG_W'(m_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else if (req_port.ready) m_valid_ff <= req_port.valid;
      if (req_port.ready) m_word_ff <= m_word_in;
   end

   assign red_valid[0] = m_valid_ff;
   assign red_word[0]  = m_word_ff;

   genvar g;
   for (g = 0; g < NR; g++) begin : g_red
      ctsp_red_cell u_cell (
         .clock(clock), .reset(reset),
         .step_k(ctsp_pkg::red_idx_type'(NR - 1 - g)),
         .in_valid(red_valid[g]), .in_ready(red_ready[g]), .in_word(red_word[g]),
         .out_valid(red_valid[g+1]), .out_ready(red_ready[g+1]),
         .out_word(red_word[g+1])
      );
   end

   // angle wrap and quadrant fold
   logic                   rot_valid [NS+1];
   logic                   rot_ready [NS+1];
   ctsp_pkg::rot_word_type rot_word  [NS+1];
   logic                   a_valid_ff;
   ctsp_pkg::rot_word_type a_word_ff, a_word_in;
   logic [ctsp_pkg::REM_W-1:0]        a_rem;
   logic signed [ctsp_pkg::REM_W+1:0] a_m;
   logic signed [ctsp_pkg::CW-1:0]    a_ang;

   assign red_ready[NR] = !a_valid_ff || rot_ready[0];

   always_comb begin
      a_rem = red_word[NR].mag[ctsp_pkg::REM_W-1:0];
      if (red_word[NR].neg && a_rem != '0)
         a_m = $signed((ctsp_pkg::REM_W+2)'(ctsp_pkg::TWO_PI_Q32))
               - $signed({2'b00, a_rem});
      else
         a_m = $signed({2'b00, a_rem});
      if (a_m >= $signed((ctsp_pkg::REM_W+2)'(ctsp_pkg::PI_Q32)))
         a_m = a_m - $signed((ctsp_pkg::REM_W+2)'(ctsp_pkg::TWO_PI_Q32));
      a_ang = ctsp_pkg::CW'(ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(a_m),
                                              7'(32 - ctsp_pkg::FRAC_BITS)));
      a_word_in.x = ctsp_pkg::GAIN_F;
      a_word_in.y = '0;
      a_word_in.flip = 1'b0;
      a_word_in.z = a_ang;
      if (a_ang > ctsp_pkg::HALF_PI_F) begin
         a_word_in.z = a_ang - ctsp_pkg::PI_F;
         a_word_in.flip = 1'b1;
      end else if (a_ang < -ctsp_pkg::HALF_PI_F) begin
         a_word_in.z = a_ang + ctsp_pkg::PI_F;
         a_word_in.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (red_ready[NR]) a_valid_ff <= red_valid[NR];
      if (red_ready[NR]) a_word_ff <= a_word_in;
   end

   assign rot_valid[0] = a_valid_ff;
   assign rot_word[0]  = a_word_ff;

   for (g = 0; g < NS; g++) begin : g_rot
      ctsp_rot_cell u_cell (
         .clock(clock), .reset(reset), .step_i(ctsp_pkg::idx_type'(g)),
         .in_valid(rot_valid[g]), .in_ready(rot_ready[g]), .in_word(rot_word[g]),
         .out_valid(rot_valid[g+1]), .out_ready(rot_ready[g+1]),
         .out_word(rot_word[g+1])
      );
   end

   // product stages
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic p5_valid_ff, p6_valid_ff, p7_valid_ff;
   logic p1_ready, p2_ready, p3_ready, p4_ready, p5_ready, p6_ready, p7_ready;
   logic vec_valid [NS+1];
   logic vec_ready [NS+1];
   ctsp_pkg::vec_word_type vec_word [NS+1];
   logic n_valid_ff, n_ready;

   logic signed [ctsp_pkg::CW-1:0] cos_v, sin_v;
   logic signed [ctsp_pkg::PW-1:0] rc_ff, rs_ff, wsf_ff, wcf_ff;
   logic signed [ctsp_pkg::PW-1:0] rc_in, rs_in, wsf_in, wcf_in;
   ctsp_pkg::side_type p2_side_ff, p3_side_ff, p4_side_ff, p5_side_ff, p6_side_ff;
   ctsp_pkg::side_type p7_side_ff, p2_side_in, p4_side_in, p7_side_in;
   logic signed [ctsp_pkg::WSW-1:0] ws_ff, wc_ff, ws_in, wc_in;
   logic signed [ctsp_pkg::QW-1:0]  pvx_ff, pvy_ff, pwc_ff, pws_ff;
   logic signed [ctsp_pkg::QW-1:0]  pvx_in, pvy_in, pwc_in, pws_in;
   logic signed [ctsp_pkg::WWW-1:0] wwc_ff, wws_ff, wwc_in, wws_in;
   logic [ctsp_pkg::LOP_W-1:0]        axl_ff, ayl_ff, axl_in, ayl_in;
   logic signed [ctsp_pkg::HIP_W-1:0] axh_ff, ayh_ff, axh_in, ayh_in;
   logic signed [ctsp_pkg::SUMW-1:0]  axs_ff, ays_ff, axs_in, ays_in;

   assign rot_ready[NS] = p1_ready;
   assign p1_ready = !p1_valid_ff || p2_ready;
   assign p2_ready = !p2_valid_ff || p3_ready;
   assign p3_ready = !p3_valid_ff || p4_ready;
   assign p4_ready = !p4_valid_ff || p5_ready;
   assign p5_ready = !p5_valid_ff || p6_ready;
   assign p6_ready = !p6_valid_ff || p7_ready;
   assign p7_ready = !p7_valid_ff || n_ready;

   always_comb begin
      cos_v  = rot_word[NS].flip ? -rot_word[NS].x : rot_word[NS].x;
      sin_v  = rot_word[NS].flip ? -rot_word[NS].y : rot_word[NS].y;
      rc_in  = rad_s * cos_v;
      rs_in  = rad_s * sin_v;
      wcf_in = angular_rate_ff * cos_v;
      wsf_in = angular_rate_ff * sin_v;

      p2_side_in    = '0;
      p2_side_in.px = ctsp_pkg::sat32(ctsp_pkg::wide_type'(center_x_ff)
         + ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(rc_ff), 7'(ctsp_pkg::FRAC_BITS)));
      p2_side_in.py = ctsp_pkg::sat32(ctsp_pkg::wide_type'(center_y_ff)
         + ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(rs_ff), 7'(ctsp_pkg::FRAC_BITS)));
      ws_in = ctsp_pkg::WSW'(ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(wsf_ff),
                                               7'(ctsp_pkg::FRAC_BITS)));
      wc_in = ctsp_pkg::WSW'(ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(wcf_ff),
                                               7'(ctsp_pkg::FRAC_BITS)));

      pvx_in = rad_s * ws_ff;
      pvy_in = rad_s * wc_ff;
      pws_in = angular_rate_ff * ws_ff;
      pwc_in = angular_rate_ff * wc_ff;

      p4_side_in    = p3_side_ff;
      p4_side_in.vx = ctsp_pkg::sat32(ctsp_pkg::rnd_shr(-ctsp_pkg::wide_type'(pvx_ff), 7'd16));
      p4_side_in.vy = ctsp_pkg::sat32(ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(pvy_ff), 7'd16));
      wwc_in = ctsp_pkg::WWW'(ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(pwc_ff), 7'd16));
      wws_in = ctsp_pkg::WWW'(ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(pws_ff), 7'd16));

      // split multiply: low part unsigned, high part signed
      axl_in = radius_ff * wwc_ff[ctsp_pkg::LO_W-1:0];
      ayl_in = radius_ff * wws_ff[ctsp_pkg::LO_W-1:0];
      axh_in = rad_s * $signed(wwc_ff[ctsp_pkg::WWW-1:ctsp_pkg::LO_W]);
      ayh_in = rad_s * $signed(wws_ff[ctsp_pkg::WWW-1:ctsp_pkg::LO_W]);

      axs_in = ctsp_pkg::SUMW'((ctsp_pkg::wide_type'(axh_ff) <<< ctsp_pkg::LO_W)
                               + ctsp_pkg::wide_type'({1'b0, axl_ff}));
      ays_in = ctsp_pkg::SUMW'((ctsp_pkg::wide_type'(ayh_ff) <<< ctsp_pkg::LO_W)
                               + ctsp_pkg::wide_type'({1'b0, ayl_ff}));

      p7_side_in    = p6_side_ff;
      p7_side_in.ax = ctsp_pkg::sat32(ctsp_pkg::rnd_shr(-ctsp_pkg::wide_type'(axs_ff), 7'd16));
      p7_side_in.ay = ctsp_pkg::sat32(ctsp_pkg::rnd_shr(-ctsp_pkg::wide_type'(ays_ff), 7'd16));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else begin
         if (p1_ready) p1_valid_ff <= rot_valid[NS];
         if (p2_ready) p2_valid_ff <= p1_valid_ff;
         if (p3_ready) p3_valid_ff <= p2_valid_ff;
         if (p4_ready) p4_valid_ff <= p3_valid_ff;
         if (p5_ready) p5_valid_ff <= p4_valid_ff;
         if (p6_ready) p6_valid_ff <= p5_valid_ff;
         if (p7_ready) p7_valid_ff <= p6_valid_ff;
      end
      if (p1_ready) begin
         rc_ff  <= rc_in;
         rs_ff  <= rs_in;
         wsf_ff <= wsf_in;
         wcf_ff <= wcf_in;
      end
      if (p2_ready) begin
         p2_side_ff <= p2_side_in;
         ws_ff      <= ws_in;
         wc_ff      <= wc_in;
      end
      if (p3_ready) begin
         p3_side_ff <= p2_side_ff;
         pvx_ff     <= pvx_in;
         pvy_ff     <= pvy_in;
         pws_ff     <= pws_in;
         pwc_ff     <= pwc_in;
      end
      if (p4_ready) begin
         p4_side_ff <= p4_side_in;
         wwc_ff     <= wwc_in;
         wws_ff     <= wws_in;
      end
      if (p5_ready) begin
         p5_side_ff <= p4_side_ff;
         axl_ff     <= axl_in;
         ayl_ff     <= ayl_in;
         axh_ff     <= axh_in;
         ayh_ff     <= ayh_in;
      end
      if (p6_ready) begin
         p6_side_ff <= p5_side_ff;
         axs_ff     <= axs_in;
         ays_ff     <= ays_in;
      end
      if (p7_ready) p7_side_ff <= p7_side_in;
   end

   // heading: normalize and fold into the right half plane
   ctsp_pkg::vec_word_type n_word_ff, n_word_in;
   logic signed [ctsp_pkg::HW-1:0] n_x, n_y, n_t, n_lim;

   assign n_ready = !n_valid_ff || vec_ready[0];

   always_comb begin
      n_x = ctsp_pkg::HW'(p7_side_ff.vx);
      n_y = ctsp_pkg::HW'(p7_side_ff.vy);
      for (int j = 0; j < 5; j++) begin
         n_lim = ctsp_pkg::HW'(1) <<< (31 - (16 >> j));
         if (n_x < n_lim && n_x > -n_lim && n_y < n_lim && n_y > -n_lim) begin
            n_x = n_x <<< (16 >> j);
            n_y = n_y <<< (16 >> j);
         end
      end
      n_t = n_x;
      n_word_in.side = p7_side_ff;
      n_word_in.zero = (p7_side_ff.vx == 32'sd0) && (p7_side_ff.vy == 32'sd0);
      n_word_in.x = n_x;
      n_word_in.y = n_y;
      n_word_in.z = '0;
      if (n_x < 0) begin
         if (n_y >= 0) begin
            n_word_in.x = n_y;
            n_word_in.y = -n_t;
            n_word_in.z = ctsp_pkg::HALF_PI_F;
         end else begin
            n_word_in.x = -n_y;
            n_word_in.y = n_t;
            n_word_in.z = -ctsp_pkg::HALF_PI_F;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) n_valid_ff <= 1'b0;
      else if (n_ready) n_valid_ff <= p7_valid_ff;
      if (n_ready) n_word_ff <= n_word_in;
   end

   assign vec_valid[0] = n_valid_ff;
   assign vec_word[0]  = n_word_ff;

   for (g = 0; g < NS; g++) begin : g_vec
      ctsp_vec_cell u_cell (
         .clock(clock), .reset(reset), .step_i(ctsp_pkg::idx_type'(g)),
         .in_valid(vec_valid[g]), .in_ready(vec_ready[g]), .in_word(vec_word[g]),
         .out_valid(vec_valid[g+1]), .out_ready(vec_ready[g+1]),
         .out_word(vec_word[g+1])
      );
   end

   // output register
   logic               h_valid_ff;
   ctsp_pkg::side_type h_side_ff;
   logic signed [18:0] h_head_ff, h_head_in;
   ctsp_pkg::wide_type h_wide;

   assign vec_ready[NS] = !h_valid_ff || rsp_port.ready;

   always_comb begin
      h_wide = ctsp_pkg::rnd_shr(ctsp_pkg::wide_type'(vec_word[NS].z), 7'(ctsp_pkg::H_RSH))
               <<< ctsp_pkg::H_LSH;
      if (h_wide > ctsp_pkg::wide_type'(ctsp_pkg::HEAD_MAX))
         h_wide = ctsp_pkg::wide_type'(ctsp_pkg::HEAD_MAX);
      if (h_wide < -ctsp_pkg::wide_type'(ctsp_pkg::HEAD_MAX))
         h_wide = -ctsp_pkg::wide_type'(ctsp_pkg::HEAD_MAX);
      h_head_in = vec_word[NS].zero ? 19'sd0 : h_wide[18:0];
   end

   always_ff @(posedge clock) begin
      if (reset) h_valid_ff <= 1'b0;
      else if (vec_ready[NS]) h_valid_ff <= vec_valid[NS];
      if (vec_ready[NS]) begin
         h_side_ff <= vec_word[NS].side;
         h_head_ff <= h_head_in;
      end
   end

   assign rsp_port.valid   = h_valid_ff;
   assign rsp_port.pos_x   = h_side_ff.px;
   assign rsp_port.pos_y   = h_side_ff.py;
   assign rsp_port.pos_z   = center_z_ff;
   assign rsp_port.vel_x   = h_side_ff.vx;
   assign rsp_port.vel_y   = h_side_ff.vy;
   assign rsp_port.acc_x   = h_side_ff.ax;
   assign rsp_port.acc_y   = h_side_ff.ay;
   assign rsp_port.heading = h_head_ff;

   `CTSP_ASSERT_NOW(a_ready_low_only_full, !req_port.ready, rsp_port.valid && !rsp_port.ready)
   `CTSP_ASSERT_NOW(a_zero_vel_heading, rsp_port.valid && rsp_port.vel_x == 32'sd0 && rsp_port.vel_y == 32'sd0, rsp_port.heading == 19'sd0)
   `CTSP_ASSERT_NOW(a_heading_range, rsp_port.valid, rsp_port.heading <= ctsp_pkg::HEAD_MAX && rsp_port.heading >= -ctsp_pkg::HEAD_MAX)
   `CTSP_ASSERT_NEXT(a_center_z_write, csr_port.valid && csr_port.index == ctsp_pkg::REG_CENTER_Z, rsp_port.pos_z == $past(csr_port.data))

endmodule

@@ src/ctsp_red_cell.sv @@
module ctsp_red_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ctsp_pkg::red_idx_type step_k,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ctsp_pkg::red_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ctsp_pkg::red_word_type out_word
);

   logic                   valid_ff;
   ctsp_pkg::red_word_type word_ff;
   ctsp_pkg::red_word_type word_in;
   logic [ctsp_pkg::MAG_W-1:0] step_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      step_val = ctsp_pkg::TWO_PI_Q32 << step_k;
      word_in  = in_word;
      if (in_word.mag >= step_val) word_in.mag = in_word.mag - step_val;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
      if (in_ready) word_ff <= word_in;
   end

endmodule

@@ src/ctsp_rot_cell.sv @@
module ctsp_rot_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ctsp_pkg::idx_type      step_i,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ctsp_pkg::rot_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ctsp_pkg::rot_word_type out_word
);

   logic                   valid_ff;
   ctsp_pkg::rot_word_type word_ff;
   ctsp_pkg::rot_word_type word_in;
   logic signed [ctsp_pkg::CW-1:0] xs;
   logic signed [ctsp_pkg::CW-1:0] ys;
   logic signed [ctsp_pkg::CW-1:0] at;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      xs = in_word.x >>> step_i;
      ys = in_word.y >>> step_i;
      at = ctsp_pkg::atan_frac(step_i);
      word_in = in_word;
      if (in_word.z >= 0) begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - at;
      end else begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
      if (in_ready) word_ff <= word_in;
   end

endmodule

@@ src/ctsp_vec_cell.sv @@
module ctsp_vec_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ctsp_pkg::idx_type      step_i,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ctsp_pkg::vec_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ctsp_pkg::vec_word_type out_word
);

   logic                   valid_ff;
   ctsp_pkg::vec_word_type word_ff;
   ctsp_pkg::vec_word_type word_in;
   logic signed [ctsp_pkg::HW-1:0] xs;
   logic signed [ctsp_pkg::HW-1:0] ys;
   logic signed [ctsp_pkg::CW-1:0] at;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      xs = in_word.x >>> step_i;
      ys = in_word.y >>> step_i;
      at = ctsp_pkg::atan_frac(step_i);
      word_in = in_word;
      if (in_word.y > 0) begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + at;
      end else begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
      if (in_ready) word_ff <= word_in;
   end

endmodule
